### src/blc_pkg.sv
// blc_pkg: types, constants and operation codes for the bounded cursor list.
// No dependencies; used by blc_ctrl, blc_cell and bounded_cursor_list.
package blc_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 8;
  localparam int FUNC_W       = 4;
  localparam int OUT_POS_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_FIRST      = 4'd0,
    FN_LAST       = 4'd1,
    FN_GOTO       = 4'd2,
    FN_PREV       = 4'd3,
    FN_NEXT       = 4'd4,
    FN_INS_BEFORE = 4'd5,
    FN_INS_AFTER  = 4'd6,
    FN_REMOVE     = 4'd7,
    FN_REPLACE    = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

### src/bounded_cursor_list.sv
// bounded_cursor_list: fixed-capacity list of signed words with a cursor.
// Instantiates blc_ctrl and a row of blc_cell; depends on blc_pkg.
//
// Usage:
//   Input channel in_*: one request per item (func, item_value, target_pos).
//   Accepted when in_valid is high and in_stall is low.
//   Output channel out_*: one result per request (cursor value and position,
//   count, empty/full flags, ignored flag). Taken when out_valid is high and
//   out_stall is low.
// Timing:
//   The cell row updates at the accepting edge; the cursor word is selected
//   from the row in the next cycle and registered, so a result is valid once
//   that register is loaded. The row update and the cursor read share the
//   cell row, so no new request is accepted while the cursor read is pending.
//   The next request may be accepted while a result is still waiting as long
//   as it is taken in the same cycle.
// Reset (rst_n low, synchronous): list empty, cursor zero, no result pending.
// Stall: while out_stall holds a result, out_* stays steady and in_stall is
//   raised; no request is lost.
module bounded_cursor_list import blc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic signed [VAL_W-1:0]     in_item_value,
  input  logic [POS_W-1:0]            in_target_pos,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_W-1:0]     out_cursor_value,
  output logic signed [OUT_POS_W-1:0] out_cursor_pos,
  output logic [OUT_POS_W-1:0]        out_item_count,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic                        out_op_ignored
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                    accept;
  logic                    pend_r;
  logic                    out_valid_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [IW-1:0]           cursor_r;
  logic [IW-1:0]           cursor_nxt;
  logic                    ign_r;
  logic                    ign_nxt;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_q [CAPACITY];

  logic signed [VAL_W-1:0]     value_r;
  logic signed [OUT_POS_W-1:0] pos_r;
  logic [OUT_POS_W-1:0]        cnt_out_r;
  logic                        empty_r;
  logic                        full_r;
  logic                        ign_out_r;

  assign in_stall = pend_r | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  blc_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .IW       (IW)
  ) u_ctrl (
    .func       (in_func),
    .target_pos (in_target_pos),
    .count      (count_r),
    .cursor     (cursor_r),
    .cmd        (cmd),
    .count_nxt  (count_nxt),
    .cursor_nxt (cursor_nxt),
    .ignored    (ign_nxt)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_q[i+1];
    end
    blc_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .cmd       (cmd),
      .new_val   (in_item_value),
      .left_val  (left_val),
      .right_val (right_val),
      .val_r     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      cursor_r    <= '0;
    end else begin
      pend_r <= accept;
      if (accept) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
      end
      if (pend_r) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ign_r <= ign_nxt;
    if (pend_r) begin
      empty_r   <= (count_r == '0);
      full_r    <= (count_r == CW'(CAPACITY));
      cnt_out_r <= OUT_POS_W'(count_r);
      ign_out_r <= ign_r;
      if (count_r == '0) begin
        value_r <= '1;
        pos_r   <= '1;
      end else begin
        value_r <= cell_q[cursor_r];
        pos_r   <= OUT_POS_W'(cursor_r);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_value = value_r;
  assign out_cursor_pos   = pos_r;
  assign out_item_count   = cnt_out_r;
  assign out_is_empty     = empty_r;
  assign out_is_full      = full_r;
  assign out_op_ignored   = ign_out_r;

endmodule

### src/blc_ctrl.sv
// blc_ctrl: decodes one request against the current count and cursor.
// Produces the command broadcast to the cell row and the next count/cursor.
// Depends on blc_pkg.
module blc_ctrl import blc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IW       = $clog2(CAPACITY)
) (
  input  logic [FUNC_W-1:0] func,
  input  logic [POS_W-1:0]  target_pos,
  input  logic [CW-1:0]     count,
  input  logic [IW-1:0]     cursor,
  output cell_cmd_t         cmd,
  output logic [CW-1:0]     count_nxt,
  output logic [IW-1:0]     cursor_nxt,
  output logic              ignored
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic          empty;
  logic          full;
  logic [CW-1:0] cur_ext;
  logic [CW-1:0] cnt_dec;
  logic [IW-1:0] at;

  assign empty   = (count == '0);
  assign full    = (count == CW'(CAPACITY));
  assign cur_ext = CW'(cursor);
  assign cnt_dec = count - CW'(1);

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.pos    = POS_W'(cursor);
    count_nxt  = count;
    cursor_nxt = cursor;
    ignored    = 1'b0;
    at         = cursor;
    unique case (func)
      FN_FIRST: begin
        if (empty) ignored = 1'b1;
        else cursor_nxt = '0;
      end
      FN_LAST: begin
        if (empty) ignored = 1'b1;
        else cursor_nxt = IW'(cnt_dec);
      end
      FN_GOTO: begin
        if (PW'(target_pos) >= PW'(count)) ignored = 1'b1;
        else cursor_nxt = IW'(target_pos);
      end
      FN_PREV: begin
        if (empty || cursor == '0) ignored = 1'b1;
        else cursor_nxt = cursor - IW'(1);
      end
      FN_NEXT: begin
        if (empty || (cur_ext + CW'(1)) >= count) ignored = 1'b1;
        else cursor_nxt = cursor + IW'(1);
      end
      FN_INS_BEFORE, FN_INS_AFTER: begin
        if (full) begin
          ignored = 1'b1;
        end else begin
          if (empty) at = '0;
          else if (func == FN_INS_AFTER) at = cursor + IW'(1);
          else at = cursor;
          cmd.op     = CELL_INSERT;
          cmd.pos    = POS_W'(at);
          count_nxt  = count + CW'(1);
          cursor_nxt = at;
        end
      end
      FN_REMOVE: begin
        if (empty) begin
          ignored = 1'b1;
        end else begin
          cmd.op    = CELL_REMOVE;
          count_nxt = cnt_dec;
          if (cnt_dec == '0) cursor_nxt = '0;
          else if (cur_ext >= cnt_dec) cursor_nxt = IW'(cnt_dec - CW'(1));
        end
      end
      FN_REPLACE: begin
        if (empty) ignored = 1'b1;
        else cmd.op = CELL_WRITE;
      end
      default: ignored = 1'b1;
    endcase
  end

endmodule

### src/blc_cell.sv
// blc_cell: one storage slot of the list row; shifts from a neighbor,
// loads the request value or holds. Depends on blc_pkg.
module blc_cell import blc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val_r
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (MY_POS == cmd.pos) val_nxt = new_val;
        else if (MY_POS > cmd.pos) val_nxt = left_val;
      end
      CELL_REMOVE: begin
        if (MY_POS >= cmd.pos) val_nxt = right_val;
      end
      CELL_WRITE: begin
        if (MY_POS == cmd.pos) val_nxt = new_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) val_r <= val_nxt;
  end

endmodule
